>>> hw/rtl/som_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package som_pkg;

  localparam int MAX_SUBSTEPS = 64;
  localparam int NSUB_W       = $clog2(MAX_SUBSTEPS + 1);

  localparam int POS_W   = 32;
  localparam int VEL_W   = 40;
  localparam int TIME_W  = 21;
  localparam int GAIN_W  = 32;
  localparam int CFG_A_W = 3;
  localparam int STEP_W  = 29;   // substep length, 2^-28 s
  localparam int ERR_W   = 49;   // spring error and gain terms, within +-2^47

  // divider: 53-bit dividend, 21-bit divisor
  localparam int DIVD_W  = 53;
  localparam int DIVS_W  = 21;
  localparam int DCNT_W  = $clog2(DIVD_W);

  // multiplier: 63-bit magnitude times 32-bit magnitude
  localparam int MAG_W   = 63;
  localparam int BMAG_W  = 32;
  localparam int PROD_W  = MAG_W + BMAG_W;

  localparam logic [MAG_W-1:0] RATE_MAG = MAG_W'(64'h4000_0000_0000_0000);
  localparam logic [MAG_W-1:0] TERM_MAG = MAG_W'(64'h0000_8000_0000_0000);

  localparam logic signed [63:0] POS_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] POS_MIN  = -64'sd2147483648;
  localparam logic signed [63:0] VEL_MAX  = 64'sd549755813887;
  localparam logic signed [63:0] VEL_MIN  = -64'sd549755813888;
  localparam logic signed [63:0] TERM_MAX = 64'sd140737488355328;
  localparam logic signed [63:0] TERM_MIN = -64'sd140737488355328;

  // shift and limit applied to a product
  typedef enum logic [2:0] {
    MM_STEP   = 3'b001,  // >> 28, limit 2^62
    MM_GAIN   = 3'b010,  // >> 24, limit 2^47
    MM_SPRING = 3'b100   // >> 12, limit 2^62
  } mul_mode_t;

  typedef struct packed {
    logic      start;
    mul_mode_t mode;
  } mul_req_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_DAMPING  = 3'd0,
    REG_STIFFINV = 3'd1,
    REG_RESPONSE = 3'd2,
    REG_CRIT     = 3'd3,
    REG_START_X  = 3'd4,
    REG_START_Y  = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/second_order_motion_smoother.sv
`timescale 1ns / 1ps
`default_nettype none

// a request runs four serial divisions and 2 + 8*n passes through the shared multiplier,
// n the substep count (1 to 64)
// a zero frame time skips integration and returns the held position
// one request at a time; the next is taken once the result sits in the output register
// reset (rst_n low, synchronous): coefficients to defaults, position and velocity to zero

module second_order_motion_smoother
  import som_pkg::*;
(
  input  wire                       clk,
  input  wire                       rst_n,

  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [CFG_A_W-1:0]        cfg_index,
  input  wire  [31:0]               cfg_data,

  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [TIME_W-1:0]         in_frame_time,
  input  wire  signed [POS_W-1:0]   in_prev_x,
  input  wire  signed [POS_W-1:0]   in_prev_y,
  input  wire  signed [POS_W-1:0]   in_cur_x,
  input  wire  signed [POS_W-1:0]   in_cur_y,

  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [POS_W-1:0]   out_x,
  output logic signed [POS_W-1:0]   out_y,
  output logic                      out_substeps_clamped
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_TV   = 10'b0000000010,
    ST_NSUB = 10'b0000000100,
    ST_H    = 10'b0000001000,
    ST_T3   = 10'b0000010000,
    ST_DP   = 10'b0000100000,
    ST_T1   = 10'b0001000000,
    ST_ACC  = 10'b0010000000,
    ST_DV   = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } som_st_t;

  som_st_t st_r;
  logic    issued_r;
  logic    ax_r;
  logic [NSUB_W-1:0] cnt_r;
  logic [NSUB_W-1:0] n_r;
  logic    clamped_r;

  logic [GAIN_W-1:0]        k1_r;
  logic [GAIN_W-1:0]        ik2_r;
  logic signed [GAIN_W-1:0] k3_r;
  logic [TIME_W-1:0]        tc_r;

  logic [TIME_W-1:0]        t_r;
  logic signed [POS_W-1:0]  prev_r [2];
  logic signed [POS_W-1:0]  cur_r  [2];
  logic signed [VEL_W-1:0]  tvel_r [2];
  logic signed [ERR_W-1:0]  t3_r   [2];
  logic signed [POS_W-1:0]  pos_r  [2];
  logic signed [VEL_W-1:0]  vel_r  [2];
  logic [STEP_W-1:0]        h_r;
  logic signed [ERR_W-1:0]  e_r;
  logic signed [63:0]       acc_r;

  logic                      out_valid_r;
  logic signed [POS_W-1:0]   out_x_r;
  logic signed [POS_W-1:0]   out_y_r;
  logic                      out_clamped_r;

  logic                     in_acc;
  logic                     cfg_acc;
  logic                     mul_state;
  logic                     div_state;
  mul_req_t                 mul_req;
  logic signed [63:0]       mul_a;
  logic signed [32:0]       mul_b;
  logic                     mul_done;
  logic signed [63:0]       mul_res;
  logic                     div_start;
  logic [DIVD_W-1:0]        div_dvd;
  logic [DIVS_W-1:0]        div_dvs;
  logic                     div_done;
  logic [DIVD_W-1:0]        div_q;

  logic [TIME_W-1:0]        tc_eff;
  logic signed [32:0]       diff;
  logic [32:0]              diff_mag;
  logic signed [VEL_W-1:0]  tvel_nxt;
  logic signed [63:0]       pos_sum;
  logic signed [POS_W-1:0]  pos_nxt;
  logic signed [63:0]       err_sum;
  logic signed [ERR_W-1:0]  e_nxt;
  logic signed [63:0]       vel_sum;
  logic signed [VEL_W-1:0]  vel_nxt;
  logic                     out_load;

  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = (st_r == ST_IDLE);
  assign out_load  = (st_r == ST_OUT) && (!out_valid_r || out_ready);

  assign mul_state = (st_r == ST_T3) || (st_r == ST_DP) || (st_r == ST_T1) ||
                     (st_r == ST_ACC) || (st_r == ST_DV);
  assign div_state = (st_r == ST_TV) || (st_r == ST_NSUB) || (st_r == ST_H);

  assign tc_eff = (tc_r == '0) ? TIME_W'(1) : tc_r;

  always_comb begin
    diff     = 33'(cur_r[ax_r]) - 33'(prev_r[ax_r]);
    diff_mag = diff[32] ? (33'd0 - diff) : diff;
  end

  // divider operands
  always_comb begin
    div_start = div_state && !issued_r;
    case (st_r)
      ST_TV: begin
        div_dvd = {diff_mag, 20'd0};
        div_dvs = t_r;
      end
      ST_NSUB: begin
        div_dvd = DIVD_W'(({1'b0, t_r} + {1'b0, tc_eff}) - 22'd1);
        div_dvs = tc_eff;
      end
      ST_H: begin
        div_dvd = DIVD_W'({t_r, 8'd0});
        div_dvs = DIVS_W'(n_r);
      end
      default: begin
        div_dvd = DIVD_W'({t_r, 8'd0});
        div_dvs = t_r;
      end
    endcase
  end

  // multiplier operands
  always_comb begin
    mul_req.start = mul_state && !issued_r;
    case (st_r)
      ST_T3: begin
        mul_a        = 64'(tvel_r[ax_r]);
        mul_b        = 33'(k3_r);
        mul_req.mode = MM_GAIN;
      end
      ST_DP: begin
        mul_a        = 64'(vel_r[ax_r]);
        mul_b        = $signed({4'd0, h_r});
        mul_req.mode = MM_STEP;
      end
      ST_T1: begin
        mul_a        = 64'(vel_r[ax_r]);
        mul_b        = $signed({1'b0, k1_r});
        mul_req.mode = MM_GAIN;
      end
      ST_ACC: begin
        mul_a        = 64'(e_r);
        mul_b        = $signed({1'b0, ik2_r});
        mul_req.mode = MM_SPRING;
      end
      ST_DV: begin
        mul_a        = acc_r;
        mul_b        = $signed({4'd0, h_r});
        mul_req.mode = MM_STEP;
      end
      default: begin
        mul_a        = acc_r;
        mul_b        = $signed({4'd0, h_r});
        mul_req.mode = MM_STEP;
      end
    endcase
  end

  // saturating updates
  always_comb begin
    if (diff[32]) begin
      tvel_nxt = (div_q > DIVD_W'(64'd549755813888)) ? VEL_MIN[VEL_W-1:0]
                                                      : (40'd0 - div_q[VEL_W-1:0]);
    end else begin
      tvel_nxt = (div_q > DIVD_W'(64'd549755813887)) ? VEL_MAX[VEL_W-1:0]
                                                      : div_q[VEL_W-1:0];
    end

    pos_sum = 64'(pos_r[ax_r]) + mul_res;
    if (pos_sum > POS_MAX)      pos_nxt = POS_MAX[POS_W-1:0];
    else if (pos_sum < POS_MIN) pos_nxt = POS_MIN[POS_W-1:0];
    else                        pos_nxt = pos_sum[POS_W-1:0];

    err_sum = 64'(cur_r[ax_r]) + 64'(t3_r[ax_r]) - 64'(pos_r[ax_r]) - mul_res;
    if (err_sum > TERM_MAX)      e_nxt = TERM_MAX[ERR_W-1:0];
    else if (err_sum < TERM_MIN) e_nxt = TERM_MIN[ERR_W-1:0];
    else                         e_nxt = err_sum[ERR_W-1:0];

    vel_sum = 64'(vel_r[ax_r]) + mul_res;
    if (vel_sum > VEL_MAX)      vel_nxt = VEL_MAX[VEL_W-1:0];
    else if (vel_sum < VEL_MIN) vel_nxt = VEL_MIN[VEL_W-1:0];
    else                        vel_nxt = vel_sum[VEL_W-1:0];
  end

  som_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  som_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (mul_req),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      issued_r    <= 1'b0;
      ax_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      k1_r        <= 32'd5340354;
      ik2_r       <= 32'd161704;
      k3_r        <= '0;
      tc_r        <= TIME_W'(110546);
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      vel_r[0]    <= '0;
      vel_r[1]    <= '0;
    end else begin
      if ((div_start) || (mul_req.start)) issued_r <= 1'b1;
      if (div_done || mul_done)           issued_r <= 1'b0;

      if (out_load)                    out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            ax_r  <= 1'b0;
            cnt_r <= '0;
            st_r  <= (in_frame_time == '0) ? ST_OUT : ST_TV;
          end
        end
        ST_TV: begin
          if (div_done) begin
            ax_r <= ~ax_r;
            if (ax_r) st_r <= ST_NSUB;
          end
        end
        ST_NSUB: if (div_done) st_r <= ST_H;
        ST_H:    if (div_done) st_r <= ST_T3;
        ST_T3: begin
          if (mul_done) begin
            ax_r <= ~ax_r;
            if (ax_r) st_r <= ST_DP;
          end
        end
        ST_DP: begin
          if (mul_done) begin
            pos_r[ax_r] <= pos_nxt;
            st_r        <= ST_T1;
          end
        end
        ST_T1:  if (mul_done) st_r <= ST_ACC;
        ST_ACC: if (mul_done) st_r <= ST_DV;
        ST_DV: begin
          if (mul_done) begin
            vel_r[ax_r] <= vel_nxt;
            ax_r        <= ~ax_r;
            if (ax_r) begin
              cnt_r <= cnt_r + 1'b1;
              st_r  <= (cnt_r == n_r - 1'b1) ? ST_OUT : ST_DP;
            end else begin
              st_r  <= ST_DP;
            end
          end
        end
        ST_OUT: if (out_load) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase

      // configuration is only written while idle
      if (cfg_acc) begin
        case (cfg_index)
          REG_DAMPING:  k1_r  <= cfg_data;
          REG_STIFFINV: ik2_r <= cfg_data;
          REG_RESPONSE: k3_r  <= cfg_data;
          REG_CRIT:     tc_r  <= cfg_data[TIME_W-1:0];
          REG_START_X: begin
            pos_r[0] <= cfg_data;
            vel_r[0] <= '0;
            vel_r[1] <= '0;
          end
          REG_START_Y: begin
            pos_r[1] <= cfg_data;
            vel_r[0] <= '0;
            vel_r[1] <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r       <= in_frame_time;
      prev_r[0] <= in_prev_x;
      prev_r[1] <= in_prev_y;
      cur_r[0]  <= in_cur_x;
      cur_r[1]  <= in_cur_y;
      clamped_r <= 1'b0;
    end
    if ((st_r == ST_TV) && div_done) tvel_r[ax_r] <= tvel_nxt;
    if ((st_r == ST_NSUB) && div_done) begin
      if (div_q > DIVD_W'(MAX_SUBSTEPS)) begin
        n_r       <= NSUB_W'(MAX_SUBSTEPS);
        clamped_r <= 1'b1;
      end else begin
        n_r <= div_q[NSUB_W-1:0];
      end
    end
    if ((st_r == ST_H) && div_done)    h_r <= div_q[STEP_W-1:0];
    if ((st_r == ST_T3) && mul_done)   t3_r[ax_r] <= mul_res[ERR_W-1:0];
    if ((st_r == ST_T1) && mul_done)   e_r <= e_nxt;
    if ((st_r == ST_ACC) && mul_done)  acc_r <= mul_res;
    if (out_load) begin
      out_x_r       <= pos_r[0];
      out_y_r       <= pos_r[1];
      out_clamped_r <= clamped_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_x                = out_x_r;
  assign out_y                = out_y_r;
  assign out_substeps_clamped = out_clamped_r;

endmodule

`default_nettype wire

>>> hw/rtl/som_div.sv
`timescale 1ns / 1ps
`default_nettype none

module som_div
  import som_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire  [DIVD_W-1:0]        dividend,
  input  wire  [DIVS_W-1:0]        divisor,
  output logic                     done,
  output logic [DIVD_W-1:0]        quotient
);

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DIVS_W-1:0] rem_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [DIVD_W-1:0] quo_r;

  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;
  logic              ge;
  logic [DIVS_W-1:0] rem_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

>>> hw/rtl/som_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module som_mul
  import som_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  mul_req_t            req,
  input  wire signed [63:0]   a,
  input  wire signed [32:0]   b,
  output logic                done,
  output logic signed [63:0]  result
);

  typedef enum logic [4:0] {
    MS_IDLE = 5'b00001,
    MS_LO   = 5'b00010,
    MS_HI   = 5'b00100,
    MS_ADD  = 5'b01000,
    MS_SAT  = 5'b10000
  } mul_st_t;

  mul_st_t           st_r;
  logic              done_r;
  logic [MAG_W-1:0]  a_mag_r;
  logic [BMAG_W-1:0] b_mag_r;
  logic              neg_r;
  mul_mode_t         mode_r;
  logic [63:0]       prod_r;
  logic [PROD_W-1:0] acc_r;
  logic [MAG_W-1:0]  mag_r;

  logic [63:0]       a_abs;
  logic [32:0]       b_abs;
  logic [PROD_W-1:0] sh;
  logic [MAG_W-1:0]  lim;
  logic [MAG_W-1:0]  mag_nxt;

  always_comb begin
    a_abs = a[63] ? (64'd0 - a) : a;
    b_abs = b[32] ? (33'd0 - b) : b;
  end

  // truncate the magnitude, then saturate symmetrically
  always_comb begin
    case (mode_r)
      MM_STEP: begin
        sh  = acc_r >> 28;
        lim = RATE_MAG;
      end
      MM_GAIN: begin
        sh  = acc_r >> 24;
        lim = TERM_MAG;
      end
      MM_SPRING: begin
        sh  = acc_r >> 12;
        lim = RATE_MAG;
      end
      default: begin
        sh  = acc_r >> 28;
        lim = RATE_MAG;
      end
    endcase
    mag_nxt = (sh > PROD_W'(lim)) ? lim : sh[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        MS_IDLE: if (req.start) st_r <= MS_LO;
        MS_LO:   st_r <= MS_HI;
        MS_HI:   st_r <= MS_ADD;
        MS_ADD:  st_r <= MS_SAT;
        MS_SAT: begin
          st_r   <= MS_IDLE;
          done_r <= 1'b1;
        end
        default: st_r <= MS_IDLE;
      endcase
    end
  end

  // two 32x32 partial products, each registered before accumulation
  always_ff @(posedge clk) begin
    case (st_r)
      MS_IDLE: begin
        if (req.start) begin
          a_mag_r <= a_abs[MAG_W-1:0];
          b_mag_r <= b_abs[BMAG_W-1:0];
          neg_r   <= a[63] ^ b[32];
          mode_r  <= req.mode;
        end
      end
      MS_LO: prod_r <= a_mag_r[31:0] * b_mag_r;
      MS_HI: begin
        acc_r  <= PROD_W'(prod_r);
        prod_r <= {1'b0, a_mag_r[MAG_W-1:32]} * b_mag_r;
      end
      MS_ADD: acc_r <= acc_r + {prod_r[MAG_W-1:0], 32'd0};
      MS_SAT: mag_r <= mag_nxt;
      default: ;
    endcase
  end

  assign done   = done_r;
  assign result = neg_r ? (64'sd0 - $signed({1'b0, mag_r})) : $signed({1'b0, mag_r});

endmodule

`default_nettype wire

>>> hw/rtl/som_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module som_checker
  import som_pkg::*;
(
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire [TIME_W-1:0]         in_frame_time,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire signed [POS_W-1:0]   out_x,
  input wire signed [POS_W-1:0]   out_y,
  input wire                      out_substeps_clamped
);

  // no result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
                                $stable(out_substeps_clamped))
    else $error("stalled result changed");

  // an accepted request makes the block busy in the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // a request with nonzero frame time must not finish early
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_frame_time != '0) |=> ##1 !in_ready)
    else $error("integration finished too early");

endmodule

bind second_order_motion_smoother som_checker u_som_checker (.*);

`default_nettype wire
